// ----- rtl/core/sdvm_pkg.sv -----
// Shared types, constants and the saturation helper for the surround downmix mixer.
`timescale 1ns / 1ps
`default_nettype none

package sdvm_pkg;

	// Mode codes of the mix_mode register
	localparam logic [1:0] MODE_GAIN    = 2'd0;
	localparam logic [1:0] MODE_DOWNMIX = 2'd1;
	localparam logic [1:0] MODE_UPMIX   = 2'd2;

	// Register indexes (byte address bit 2)
	localparam logic REG_MIX_MODE    = 1'b0;
	localparam logic REG_VOLUME_GAIN = 1'b1;

	localparam logic [15:0] GAIN_RESET = 16'd4096;

	// Q1.15 downmix coefficients
	localparam logic signed [15:0] COEF_SIDE = 16'sd23167;
	localparam logic signed [15:0] COEF_LFE  = 16'sd8225;

	localparam int GAIN_FRAC_BITS = 12;
	localparam int MIX_FRAC_BITS  = 27;

	typedef logic signed [15:0] sample_t;
	typedef logic signed [32:0] sdvm_prod_t;  // sample * gain, Q.12
	typedef logic signed [49:0] sdvm_acc_t;   // downmix sum * gain, Q.27

	// Per-stage load strobes shared by the lanes and the merge stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} sdvm_load_t;

	// Clamp a wide signed value to the 16-bit sample range
	function automatic sample_t sat16(input sdvm_acc_t v);
		sample_t r;
		if (v > 50'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -50'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/surround_downmix_volume_mixer_top.sv -----
// Top level of the surround downmix / volume mixer: handshake, registers, lanes and merge.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | in_front_left .. in_back_right, 16b signed
//  output   | out_valid / out_stall| out_front_left .. out_back_right, 16b signed
//  config   | APB psel/penable     | 0x0 mix_mode[1:0], 0x4 volume_gain[15:0]
//
// One frame per cycle sustained while out_stall is low; the lane pipeline registers, in order,
// coefficient products, sum, split gain multiply, combine and saturate/select.
// arst_n clears all stage valids and loads mix_mode 0, volume_gain 4096.
// A stall on the output backs up stage by stage; empty stages keep filling, so
// input is taken while a finished frame waits.
`timescale 1ns / 1ps
`default_nettype none

module surround_downmix_volume_mixer_top (
	input  wire                clk,
	input  wire                arst_n,
	// input channel
	input  wire                in_valid,
	output logic               in_stall,
	input  sdvm_pkg::sample_t  in_front_left,
	input  sdvm_pkg::sample_t  in_front_right,
	input  sdvm_pkg::sample_t  in_center,
	input  sdvm_pkg::sample_t  in_low_freq,
	input  sdvm_pkg::sample_t  in_back_left,
	input  sdvm_pkg::sample_t  in_back_right,
	// output channel
	output logic               out_valid,
	input  wire                out_stall,
	output sdvm_pkg::sample_t  out_front_left,
	output sdvm_pkg::sample_t  out_front_right,
	output sdvm_pkg::sample_t  out_center,
	output sdvm_pkg::sample_t  out_low_freq,
	output sdvm_pkg::sample_t  out_back_left,
	output sdvm_pkg::sample_t  out_back_right,
	// configuration
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [2:0]          paddr,
	input  wire [31:0]         pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import sdvm_pkg::*;

	logic [1:0]  mix_mode_q;
	logic [15:0] volume_gain_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	sdvm_load_t ld;

	sample_t    smp [6];
	sdvm_prod_t scl_prod [6];
	sdvm_acc_t  mix_acc [2];
	sample_t    res [6];

	// Config registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_mode_q    <= MODE_GAIN;
			volume_gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MIX_MODE:    mix_mode_q    <= pwdata[1:0];
				REG_VOLUME_GAIN: volume_gain_q <= pwdata[15:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MIX_MODE:    prdata = {30'b0, mix_mode_q};
			REG_VOLUME_GAIN: prdata = {16'b0, volume_gain_q};
			default:         prdata = '0;
		endcase
	end

	// Stage ready chain: a stage takes new data when empty or when it moves on
	assign rdy_s5 = !vld_s5 || !out_stall;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	assign ld.s1 = rdy_s1 && in_valid;
	assign ld.s2 = rdy_s2 && vld_s1;
	assign ld.s3 = rdy_s3 && vld_s2;
	assign ld.s4 = rdy_s4 && vld_s3;
	assign ld.s5 = rdy_s5 && vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	assign out_valid = vld_s5;

	// Gain lanes, one per channel
	assign smp[0] = in_front_left;
	assign smp[1] = in_front_right;
	assign smp[2] = in_center;
	assign smp[3] = in_low_freq;
	assign smp[4] = in_back_left;
	assign smp[5] = in_back_right;

	for (genvar g = 0; g < 6; g++) begin : g_scl
		sdvm_scale_lane u_scl (
			.clk    (clk),
			.ld     (ld),
			.sample (smp[g]),
			.gain   (volume_gain_q),
			.prod   (scl_prod[g])
		);
	end

	// Downmix lanes, left and right
	sdvm_dmix_lane u_mix_l (
		.clk   (clk),
		.ld    (ld),
		.front (in_front_left),
		.cen   (in_center),
		.lfe   (in_low_freq),
		.back  (in_back_left),
		.gain  (volume_gain_q),
		.acc   (mix_acc[0])
	);

	sdvm_dmix_lane u_mix_r (
		.clk   (clk),
		.ld    (ld),
		.front (in_front_right),
		.cen   (in_center),
		.lfe   (in_low_freq),
		.back  (in_back_right),
		.gain  (volume_gain_q),
		.acc   (mix_acc[1])
	);

	// Merge and output register
	sdvm_merge u_merge (
		.clk      (clk),
		.ld       (ld),
		.mode     (mix_mode_q),
		.scl_prod (scl_prod),
		.mix_acc  (mix_acc),
		.res      (res)
	);

	assign out_front_left  = res[0];
	assign out_front_right = res[1];
	assign out_center      = res[2];
	assign out_low_freq    = res[3];
	assign out_back_left   = res[4];
	assign out_back_right  = res[5];

endmodule

`default_nettype wire

// ----- rtl/core/sdvm_scale_lane.sv -----
// One gain lane: multiplies a channel sample by the gain and carries it down the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module sdvm_scale_lane (
	input  wire                  clk,
	input  sdvm_pkg::sdvm_load_t ld,
	input  sdvm_pkg::sample_t    sample,
	input  wire [15:0]           gain,
	output sdvm_pkg::sdvm_prod_t prod
);
	import sdvm_pkg::*;

	sdvm_prod_t prod_s1;
	sdvm_prod_t prod_s2;
	sdvm_prod_t prod_s3;
	sdvm_prod_t prod_s4;

	// Multiply in stage 1, then delay to line up with the downmix lanes
	always_ff @(posedge clk) begin
		if (ld.s1) begin
			prod_s1 <= 33'(sample) * 33'($signed({1'b0, gain}));
		end
		if (ld.s2) begin
			prod_s2 <= prod_s1;
		end
		if (ld.s3) begin
			prod_s3 <= prod_s2;
		end
		if (ld.s4) begin
			prod_s4 <= prod_s3;
		end
	end

	assign prod = prod_s4;

endmodule

`default_nettype wire

// ----- rtl/core/sdvm_dmix_lane.sv -----
// One downmix lane: weighted sum of four channels, then a split multiply by the gain.
`timescale 1ns / 1ps
`default_nettype none

module sdvm_dmix_lane (
	input  wire                  clk,
	input  sdvm_pkg::sdvm_load_t ld,
	input  sdvm_pkg::sample_t    front,
	input  sdvm_pkg::sample_t    cen,
	input  sdvm_pkg::sample_t    lfe,
	input  sdvm_pkg::sample_t    back,
	input  wire [15:0]           gain,
	output sdvm_pkg::sdvm_acc_t  acc
);
	import sdvm_pkg::*;

	sample_t            front_s1;
	logic signed [31:0] cen_s1;
	logic signed [31:0] lfe_s1;
	logic signed [31:0] back_s1;
	logic signed [32:0] sum_s2;
	logic        [31:0] pp_lo_s3;
	logic signed [33:0] pp_hi_s3;
	sdvm_acc_t          acc_s4;

	always_ff @(posedge clk) begin
		// Stage 1: coefficient products
		if (ld.s1) begin
			front_s1 <= front;
			cen_s1   <= 32'(cen) * 32'(COEF_SIDE);
			lfe_s1   <= 32'(lfe) * 32'(COEF_LFE);
			back_s1  <= 32'(back) * 32'(COEF_SIDE);
		end
		// Stage 2: Q.15 sum, front at unity
		if (ld.s2) begin
			sum_s2 <= (33'(front_s1) <<< 15) + 33'(cen_s1) + 33'(lfe_s1) + 33'(back_s1);
		end
		// Stage 3: sum times gain as two partial products
		if (ld.s3) begin
			pp_lo_s3 <= 32'(sum_s2[15:0]) * 32'(gain);
			pp_hi_s3 <= 34'($signed(sum_s2[32:16])) * 34'($signed({1'b0, gain}));
		end
		// Stage 4: combine partial products
		if (ld.s4) begin
			acc_s4 <= (50'(pp_hi_s3) <<< 16) + $signed({18'b0, pp_lo_s3});
		end
	end

	assign acc = acc_s4;

endmodule

`default_nettype wire

// ----- rtl/core/sdvm_merge.sv -----
// Merge stage: truncates and saturates lane results and selects them by mode into the output register.
`timescale 1ns / 1ps
`default_nettype none

module sdvm_merge (
	input  wire                  clk,
	input  sdvm_pkg::sdvm_load_t ld,
	input  wire [1:0]            mode,
	input  sdvm_pkg::sdvm_prod_t scl_prod [6],
	input  sdvm_pkg::sdvm_acc_t  mix_acc [2],
	output sdvm_pkg::sample_t    res [6]
);
	import sdvm_pkg::*;

	sample_t   scl_sat [6];
	sample_t   mix_sat [2];
	sample_t   res_q   [6];
	sdvm_acc_t scl_ext;
	sdvm_acc_t mix_ext;

	// Truncate toward zero (bias negatives before the shift), then clamp
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			scl_ext = 50'(scl_prod[i]);
			if (scl_prod[i] < 0) begin
				scl_ext = scl_ext + 50'sd4095;
			end
			scl_sat[i] = sat16(scl_ext >>> GAIN_FRAC_BITS);
		end
		for (int j = 0; j < 2; j++) begin
			mix_ext = mix_acc[j];
			if (mix_acc[j] < 0) begin
				mix_ext = mix_ext + 50'sd134217727;
			end
			mix_sat[j] = sat16(mix_ext >>> MIX_FRAC_BITS);
		end
	end

	// Output register, selected by mode; unused mode code acts as gain only
	always_ff @(posedge clk) begin
		if (ld.s5) begin
			case (mode)
				MODE_DOWNMIX: begin
					res_q[0] <= mix_sat[0];
					res_q[1] <= mix_sat[1];
					for (int k = 2; k < 6; k++) res_q[k] <= '0;
				end
				MODE_UPMIX: begin
					res_q[0] <= scl_sat[0];
					res_q[1] <= scl_sat[1];
					for (int k = 2; k < 6; k++) res_q[k] <= '0;
				end
				default: begin
					for (int k = 0; k < 6; k++) res_q[k] <= scl_sat[k];
				end
			endcase
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/sdvm_checker.sv -----
// Port-level checker for the surround downmix mixer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sdvm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [15:0] out_front_left,
	input wire [15:0] out_back_right,
	input wire        psel,
	input wire        penable,
	input wire        pwrite,
	input wire        pready,
	input wire [2:0]  paddr,
	input wire [31:0] pwdata,
	input wire [31:0] prdata
);

	// A stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled result transaction keeps its payload on out_front_left and out_back_right
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_front_left) && $stable(out_back_right))
		else $error("output payload changed while stalled");

	// Pipeline is empty once reset has been seen at a clock edge
	a_rst_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high after reset");

	// A gain write reads back on the following cycle
	a_gain_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2]
		|=> !paddr[2] || (prdata == {16'b0, $past(pwdata[15:0])}))
		else $error("volume_gain readback mismatch");

endmodule

bind surround_downmix_volume_mixer_top sdvm_checker u_sdvm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.out_front_left (out_front_left),
	.out_back_right (out_back_right),
	.psel           (psel),
	.penable        (penable),
	.pwrite         (pwrite),
	.pready         (pready),
	.paddr          (paddr),
	.pwdata         (pwdata),
	.prdata         (prdata)
);

`default_nettype wire
